### rtl/div64_pkg.sv
// ----------------------------------------------------------------------------
// div64_pkg
// Shared types and defaults for the pipelined 64 by 32 integer divider.
// ----------------------------------------------------------------------------
package div64_pkg;

   localparam int DIVIDEND_BITS_DEF = 64;
   localparam int DIVISOR_BITS_DEF  = 32;

   // per-word control flags carried alongside the data through the array
   typedef struct packed {
      logic neg_quot;   // negate quotient at the end
      logic neg_rem;    // negate remainder at the end
      logic div_zero;   // divisor was zero
      logic ovf;        // signed minimum divided by minus one
   } flags_type;

endpackage

### rtl/div64_prep.sv
// ----------------------------------------------------------------------------
// div64_prep
// Input stage: operand magnitudes, sign bookkeeping and special-case flags.
// ----------------------------------------------------------------------------
module div64_prep #(
   parameter int DIVIDEND_BITS = div64_pkg::DIVIDEND_BITS_DEF,
   parameter int DIVISOR_BITS  = div64_pkg::DIVISOR_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  logic                     is_signed,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output logic [DIVIDEND_BITS-1:0] shift_out,
   output logic [DIVISOR_BITS-1:0]  div_out,
   output div64_pkg::flags_type     flags_out
);

   localparam logic [DIVIDEND_BITS-1:0] MinDividend = {1'b1, {(DIVIDEND_BITS-1){1'b0}}};

   logic                     valid_ff, valid_in;
   logic [DIVIDEND_BITS-1:0] shift_ff, shift_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;
   div64_pkg::flags_type     flags_ff, flags_in;
   logic                     div_zero, neg_a, neg_b;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      div_zero = (divisor == '0);
      // a zero divisor passes the raw dividend bits through the array
      neg_a    = is_signed && dividend[DIVIDEND_BITS-1] && !div_zero;
      neg_b    = is_signed && divisor[DIVISOR_BITS-1];
      shift_in = neg_a ? (~dividend + 1'b1) : dividend;
      div_in   = neg_b ? (~divisor + 1'b1) : divisor;
      flags_in.neg_quot = neg_a ^ neg_b;
      flags_in.neg_rem  = neg_a;
      flags_in.div_zero = div_zero;
      flags_in.ovf      = is_signed && (dividend == MinDividend) && (divisor == '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         shift_ff <= shift_in;
         div_ff   <= div_in;
         flags_ff <= flags_in;
      end
   end

   assign dn_valid  = valid_ff;
   assign shift_out = shift_ff;
   assign div_out   = div_ff;
   assign flags_out = flags_ff;

endmodule

### rtl/div64_cell.sv
// ----------------------------------------------------------------------------
// div64_cell
// One restoring division step: shift in a dividend bit, trial subtract,
// keep or restore, and shift the quotient bit into the word.
// ----------------------------------------------------------------------------
module div64_cell #(
   parameter int DIVIDEND_BITS = div64_pkg::DIVIDEND_BITS_DEF,
   parameter int DIVISOR_BITS  = div64_pkg::DIVISOR_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  logic [DIVISOR_BITS-1:0]  rem_in_data,
   input  logic [DIVIDEND_BITS-1:0] shift_in_data,
   input  logic [DIVISOR_BITS-1:0]  div_in_data,
   input  div64_pkg::flags_type     flags_in_data,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output logic [DIVISOR_BITS-1:0]  rem_out,
   output logic [DIVIDEND_BITS-1:0] shift_out,
   output logic [DIVISOR_BITS-1:0]  div_out,
   output div64_pkg::flags_type     flags_out
);

   logic                     valid_ff, valid_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] shift_ff, shift_in;
   logic [DIVISOR_BITS-1:0]  div_ff;
   div64_pkg::flags_type     flags_ff;
   logic [DIVISOR_BITS+1:0]  diff;
   logic                     next_bit, quot_bit;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      next_bit = shift_in_data[DIVIDEND_BITS-1];
      diff     = {1'b0, rem_in_data, next_bit} - {2'b00, div_in_data};
      if (flags_in_data.div_zero) begin
         // zero divisor: dividend bits circulate unchanged
         quot_bit = next_bit;
         rem_in   = rem_in_data;
      end else if (!diff[DIVISOR_BITS+1]) begin
         quot_bit = 1'b1;
         rem_in   = diff[DIVISOR_BITS-1:0];
      end else begin
         quot_bit = 1'b0;
         rem_in   = {rem_in_data[DIVISOR_BITS-2:0], next_bit};
      end
      shift_in = {shift_in_data[DIVIDEND_BITS-2:0], quot_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_in;
         div_ff   <= div_in_data;
         flags_ff <= flags_in_data;
      end
   end

   assign dn_valid  = valid_ff;
   assign rem_out   = rem_ff;
   assign shift_out = shift_ff;
   assign div_out   = div_ff;
   assign flags_out = flags_ff;

endmodule

### rtl/div64_post.sv
// ----------------------------------------------------------------------------
// div64_post
// Output stage: sign fix-up of quotient and remainder, zero-divisor result, result register.
// ----------------------------------------------------------------------------
module div64_post #(
   parameter int DIVIDEND_BITS = div64_pkg::DIVIDEND_BITS_DEF,
   parameter int DIVISOR_BITS  = div64_pkg::DIVISOR_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  logic [DIVISOR_BITS-1:0]  rem_in_data,
   input  logic [DIVIDEND_BITS-1:0] shift_in_data,
   input  div64_pkg::flags_type     flags_in_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DIVIDEND_BITS-1:0] rsp_quotient,
   output logic [DIVIDEND_BITS-1:0] rsp_remainder,
   output logic                     rsp_div_by_zero,
   output logic                     rsp_overflow
);

   localparam int WideBits = (DIVIDEND_BITS > DIVISOR_BITS) ? DIVIDEND_BITS : DIVISOR_BITS;

   logic                     valid_ff, valid_in;
   logic [DIVIDEND_BITS-1:0] quot_ff, quot_in;
   logic [DIVIDEND_BITS-1:0] rem_ff, rem_in;
   logic                     dz_ff, ovf_ff;
   logic [WideBits-1:0]      rem_wide;
   logic [DIVIDEND_BITS-1:0] rem_mag;

   assign up_ready = !valid_ff || !rsp_stall;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      // remainder does not exceed the dividend magnitude, so it fits the result width
      rem_wide = WideBits'(rem_in_data);
      rem_mag  = rem_wide[DIVIDEND_BITS-1:0];
      if (flags_in_data.div_zero) begin
         quot_in = '0;
         rem_in  = shift_in_data;
      end else begin
         quot_in = flags_in_data.neg_quot ? (~shift_in_data + 1'b1) : shift_in_data;
         rem_in  = flags_in_data.neg_rem ? (~rem_mag + 1'b1) : rem_mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         dz_ff   <= flags_in_data.div_zero;
         ovf_ff  <= flags_in_data.ovf;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_quotient    = quot_ff;
   assign rsp_remainder   = rem_ff;
   assign rsp_div_by_zero = dz_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

### rtl/divide_64_by_32_with_remainder_core.sv
// path: request word through the input, cell and output stage registers in turn
// throughput: one word per cycle unless rsp_stall holds; DIVIDEND_BITS division
//   cells, one quotient bit each, with an input stage and a sign fix-up output stage
// every stage holds independently, so bubbles close up while the response stalls
// reset: synchronous, clears the valid bits of all stages; the pipe is empty after it
// ----------------------------------------------------------------------------
// divide_64_by_32_with_remainder_core
// Pipelined restoring divider, signed or unsigned, with quotient and remainder.
// ----------------------------------------------------------------------------
module divide_64_by_32_with_remainder_core #(
   parameter int DIVIDEND_BITS = div64_pkg::DIVIDEND_BITS_DEF,
   parameter int DIVISOR_BITS  = div64_pkg::DIVISOR_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic [DIVIDEND_BITS-1:0] req_dividend,
   input  logic [DIVISOR_BITS-1:0]  req_divisor,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DIVIDEND_BITS-1:0] rsp_quotient,
   output logic [DIVIDEND_BITS-1:0] rsp_remainder,
   output logic                     rsp_div_by_zero,
   output logic                     rsp_overflow
);

   logic                     valid_w [0:DIVIDEND_BITS];
   logic                     ready_w [0:DIVIDEND_BITS+1];
   logic [DIVISOR_BITS-1:0]  rem_w   [0:DIVIDEND_BITS];
   logic [DIVIDEND_BITS-1:0] shift_w [0:DIVIDEND_BITS];
   logic [DIVISOR_BITS-1:0]  div_w   [0:DIVIDEND_BITS];
   div64_pkg::flags_type     flags_w [0:DIVIDEND_BITS];

   assign req_stall = !ready_w[0];
   assign rem_w[0]  = '0;

   div64_prep #(
      .DIVIDEND_BITS(DIVIDEND_BITS),
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (ready_w[0]),
      .is_signed(req_type),
      .dividend (req_dividend),
      .divisor  (req_divisor),
      .dn_valid (valid_w[0]),
      .dn_ready (ready_w[1]),
      .shift_out(shift_w[0]),
      .div_out  (div_w[0]),
      .flags_out(flags_w[0])
   );

   for (genvar i = 0; i < DIVIDEND_BITS; i++) begin : g_cell
      div64_cell #(
         .DIVIDEND_BITS(DIVIDEND_BITS),
         .DIVISOR_BITS (DIVISOR_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .up_valid     (valid_w[i]),
         .up_ready     (ready_w[i+1]),
         .rem_in_data  (rem_w[i]),
         .shift_in_data(shift_w[i]),
         .div_in_data  (div_w[i]),
         .flags_in_data(flags_w[i]),
         .dn_valid     (valid_w[i+1]),
         .dn_ready     (ready_w[i+2]),
         .rem_out      (rem_w[i+1]),
         .shift_out    (shift_w[i+1]),
         .div_out      (div_w[i+1]),
         .flags_out    (flags_w[i+1])
      );
   end

   div64_post #(
      .DIVIDEND_BITS(DIVIDEND_BITS),
      .DIVISOR_BITS (DIVISOR_BITS)
   ) u_post (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (valid_w[DIVIDEND_BITS]),
      .up_ready       (ready_w[DIVIDEND_BITS+1]),
      .rem_in_data    (rem_w[DIVIDEND_BITS]),
      .shift_in_data  (shift_w[DIVIDEND_BITS]),
      .flags_in_data  (flags_w[DIVIDEND_BITS]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_quotient   (rsp_quotient),
      .rsp_remainder  (rsp_remainder),
      .rsp_div_by_zero(rsp_div_by_zero),
      .rsp_overflow   (rsp_overflow)
   );

`ifndef SYNTHESIS
   // a free response side means every stage can move
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> (rsp_quotient == '0) && !rsp_overflow)
      else $error("zero divisor word with non-zero quotient or overflow");

   a_ovf_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> (rsp_remainder == '0) && rsp_quotient[DIVIDEND_BITS-1])
      else $error("overflow word without wrapped quotient and zero remainder");
`endif

endmodule

### verif/divide_64_by_32_with_remainder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// divide_64_by_32_with_remainder_core_tb
// Self-checking bench for the pipelined divider: directed corner divisions,
// a back-pressure fill of the pipe, then random bursts against a scoreboard.
// ----------------------------------------------------------------------------
module divide_64_by_32_with_remainder_core_tb;

   localparam int NB = div64_pkg::DIVIDEND_BITS_DEF;
   localparam int DB = div64_pkg::DIVISOR_BITS_DEF;

   localparam bit DIV_UNSIGNED = 1'b0;
   localparam bit DIV_SIGNED   = 1'b1;

   localparam int WORD_TARGET = 900;
   localparam int LONG_HOLD   = 400;
   localparam int FILL_WORDS  = 150;
   localparam int QUIET_LIMIT = 5000;

   localparam logic [NB-1:0] DIVIDEND_MIN = {1'b1, {(NB-1){1'b0}}};
   localparam logic [NB-1:0] DIVIDEND_MAX = {NB{1'b1}};
   localparam logic [DB-1:0] DIVISOR_ONES = {DB{1'b1}};

   typedef struct {
      logic [NB-1:0] quotient;
      logic [NB-1:0] remainder;
      logic          div_by_zero;
      logic          overflow;
   } quot_rem_type;

   class division_scoreboard;
      quot_rem_type pending_q[$];
      int unsigned  failures;

      function quot_rem_type divide(bit is_signed, logic [NB-1:0] a, logic [DB-1:0] b);
         quot_rem_type  res;
         logic [NB-1:0] mag_a;
         logic [DB-1:0] mag_b;
         logic [NB-1:0] wide_b;
         logic          neg_a;
         logic          neg_b;
         res = '{default: '0};
         neg_a = a[NB-1];
         neg_b = b[DB-1];
         if (b == '0) begin
            res.remainder   = a;
            res.div_by_zero = 1'b1;
         end else if (!is_signed) begin
            wide_b        = NB'(b);
            res.quotient  = a / wide_b;
            res.remainder = a % wide_b;
         end else begin
            mag_a = neg_a ? (~a + 1'b1) : a;
            mag_b = neg_b ? (~b + 1'b1) : b;
            wide_b = NB'(mag_b);
            res.quotient  = mag_a / wide_b;
            res.remainder = mag_a % wide_b;
            if (neg_a != neg_b)
               res.quotient = ~res.quotient + 1'b1;
            if (neg_a)
               res.remainder = ~res.remainder + 1'b1;
            res.overflow = (a == DIVIDEND_MIN) && (b == DIVISOR_ONES);
         end
         return res;
      endfunction

      function void note_request(bit is_signed, logic [NB-1:0] a, logic [DB-1:0] b);
         pending_q.push_back(divide(is_signed, a, b));
      endfunction

      function void check_response(quot_rem_type got);
         quot_rem_type want;
         if (pending_q.size() == 0) begin
            $error("response word with no division outstanding");
            failures++;
            return;
         end
         want = pending_q.pop_front();
         if (got.quotient !== want.quotient) begin
            $error("quotient: expected %h, got %h", want.quotient, got.quotient);
            failures++;
         end
         if (got.remainder !== want.remainder) begin
            $error("remainder: expected %h, got %h", want.remainder, got.remainder);
            failures++;
         end
         if (got.div_by_zero !== want.div_by_zero) begin
            $error("div_by_zero: expected %b, got %b", want.div_by_zero, got.div_by_zero);
            failures++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, got.overflow);
            failures++;
         end
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_type = DIV_UNSIGNED;
   logic [NB-1:0] req_dividend = '0;
   logic [DB-1:0] req_divisor = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [NB-1:0] rsp_quotient;
   logic [NB-1:0] rsp_remainder;
   logic          rsp_div_by_zero;
   logic          rsp_overflow;

   division_scoreboard sb;
   int unsigned        words_sent;
   int unsigned        quiet_cycles;
   bit                 hold_req;
   bit                 hold_active;

   divide_64_by_32_with_remainder_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_dividend    (req_dividend),
      .req_divisor     (req_divisor),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_quotient    (rsp_quotient),
      .rsp_remainder   (rsp_remainder),
      .rsp_div_by_zero (rsp_div_by_zero),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // both channels watched at the edge; the watchdog counts edges with no word moving
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall)
            sb.note_request(req_type, req_dividend, req_divisor);
         if (rsp_valid && !rsp_stall)
            sb.check_response('{rsp_quotient, rsp_remainder, rsp_div_by_zero, rsp_overflow});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   initial begin : rsp_side
      int style;
      int run_len;
      int k;
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            hold_active = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_active = 1'b0;
            hold_req = 1'b0;
         end else begin
            style = $urandom_range(0, 3);
            run_len = $urandom_range(20, 200);
            for (k = 0; k < run_len; k++) begin
               case (style)
                  0: begin
                     rsp_stall <= 1'b0;
                  end
                  1: begin
                     rsp_stall <= ($urandom_range(0, 1) == 1);
                  end
                  2: begin
                     rsp_stall <= ((k % 4) == 3);
                  end
                  default: begin
                     rsp_stall <= ($urandom_range(0, 7) != 0);
                  end
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // present one word and hold it until it is taken
   task automatic send_word(input bit is_signed, input logic [NB-1:0] a,
                            input logic [DB-1:0] b);
      req_valid    <= 1'b1;
      req_type     <= is_signed;
      req_dividend <= a;
      req_divisor  <= b;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic idle_for(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic pick_operands(output bit is_signed, output logic [NB-1:0] a,
                                output logic [DB-1:0] b);
      logic [NB-1:0] factor;
      int            kind;
      kind = $urandom_range(0, 9);
      is_signed = 1'($urandom_range(0, 1));
      a = {$urandom, $urandom};
      b = $urandom;
      case (kind)
         0, 1, 2: begin
         end
         3: begin
            a = NB'($urandom_range(0, 1000));
            b = $urandom_range(1, 50);
         end
         4: begin
            b = '0;
         end
         5: begin
            b = ($urandom_range(0, 1) == 1) ? DIVISOR_ONES : DB'(1);
            if ($urandom_range(0, 2) == 0)
               a = DIVIDEND_MIN;
         end
         6: begin
            // exact multiple plus a small remainder, sign flipped at random
            b = ($urandom_range(0, 1) == 1) ? DB'($urandom_range(1, 65535)) : b | DB'(1);
            factor = NB'($urandom);
            a = factor * NB'(b) + NB'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1)
               a = ~a + 1'b1;
         end
         7: begin
            // sign-extended 32-bit dividend keeps the signed quotient short
            a = {{(NB-DB){a[DB-1]}}, a[DB-1:0]};
         end
         8: begin
            b = DB'(1) << $urandom_range(0, DB-1);
         end
         default: begin
            b = b >> $urandom_range(0, DB-1);
            if (b == '0)
               b = DB'(3);
         end
      endcase
   endtask

   initial begin : main
      bit            is_signed;
      logic [NB-1:0] a;
      logic [DB-1:0] b;
      int            burst;
      int            gap;
      int            n;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner divisions
      send_word(DIV_UNSIGNED, '0, DB'(1));
      send_word(DIV_UNSIGNED, DIVIDEND_MAX, DB'(1));
      send_word(DIV_UNSIGNED, DIVIDEND_MAX, DIVISOR_ONES);
      send_word(DIV_UNSIGNED, '0, '0);
      send_word(DIV_UNSIGNED, DIVIDEND_MAX, '0);
      send_word(DIV_SIGNED, DIVIDEND_MAX, '0);
      send_word(DIV_SIGNED, DIVIDEND_MIN, '0);
      idle_for(3);
      send_word(DIV_SIGNED, DIVIDEND_MIN, DIVISOR_ONES);
      send_word(DIV_UNSIGNED, DIVIDEND_MIN, DIVISOR_ONES);
      send_word(DIV_SIGNED, DIVIDEND_MIN, DB'(1));
      send_word(DIV_SIGNED, ~DIVIDEND_MIN, DIVISOR_ONES);
      send_word(DIV_SIGNED, -NB'(7), DB'(2));
      send_word(DIV_SIGNED, NB'(7), -DB'(2));
      send_word(DIV_SIGNED, -NB'(7), -DB'(2));
      idle_for(1);
      send_word(DIV_UNSIGNED, NB'(100), DB'(7));
      send_word(DIV_UNSIGNED, DIVIDEND_MAX, {1'b0, {(DB-1){1'b1}}});
      send_word(DIV_SIGNED, ~DIVIDEND_MIN, {1'b1, {(DB-1){1'b0}}});
      send_word(DIV_SIGNED, DIVIDEND_MIN, {1'b1, {(DB-1){1'b0}}});
      send_word(DIV_UNSIGNED, NB'(1), DIVISOR_ONES);
      send_word(DIV_SIGNED, NB'(5), DB'(9));
      send_word(DIV_SIGNED, -NB'(5), DB'(9));
      wait_drained();

      // fill the pipe against a long receiver hold-off
      hold_req = 1'b1;
      wait (hold_active);
      for (n = 0; n < FILL_WORDS; n++) begin
         pick_operands(is_signed, a, b);
         send_word(is_signed, a, b);
      end
      wait_drained();

      while (words_sent < WORD_TARGET) begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                             : $urandom_range(1, 40);
         for (n = 0; n < burst && words_sent < WORD_TARGET; n++) begin
            pick_operands(is_signed, a, b);
            send_word(is_signed, a, b);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0)
            idle_for(gap);
      end

      wait_drained();
      repeat (NB + 8) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
